[hdl/assert_macros.svh]
// Assertion macros for the checker file.
// Each expects a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high
`define TOFRT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset
`define TOFRT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tofrt_pkg.sv]
// ----------------------------------------------------------------------------
// tofrt_pkg
// Constants and types for the time-of-flight ring trigger logic.
// ----------------------------------------------------------------------------
package tofrt_pkg;

  // default ring sizes
  localparam int BARREL_COUNTERS_DEF = 88;
  localparam int ENDCAP_CHANNELS_DEF = 48;

  // padded widths of the internal ring vectors
  localparam int BARREL_MAX = 128;
  localparam int ENDCAP_MAX = 64;

  // field widths
  localparam int LOW_W     = 64;
  localparam int HIGH_W    = 24;
  localparam int ENDCAP_W  = 48;
  localparam int SCINT_W   = 24;
  localparam int LAYER_W   = 2;

  // back-to-back windows
  localparam int BB_BARREL_MIN  = 38;
  localparam int BB_BARREL_SPAN = 13;
  localparam int BB_ENDCAP_MIN  = 20;
  localparam int BB_ENDCAP_SPAN = 9;

  // layer mode codes
  localparam logic [LAYER_W-1:0] LAYER_INNER = 2'd1;
  localparam logic [LAYER_W-1:0] LAYER_BOTH  = 2'd2;
  localparam logic [LAYER_W-1:0] LAYER_RESET = LAYER_BOTH;

  typedef struct packed {
    logic one;
    logic two;
  } cluster_flags_t;

endpackage

[hdl/tofrt_if.sv]
// ----------------------------------------------------------------------------
// tofrt_hits_if / tofrt_trig_if
// Valid/ready channels for event hit maps and trigger results.
// ----------------------------------------------------------------------------
interface tofrt_hits_if import tofrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LOW_W-1:0]    inner_low;
  logic [HIGH_W-1:0]   inner_high;
  logic [LOW_W-1:0]    outer_low;
  logic [HIGH_W-1:0]   outer_high;
  logic [ENDCAP_W-1:0] east_hits;
  logic [ENDCAP_W-1:0] west_hits;

  modport source (
    output valid, inner_low, inner_high, outer_low, outer_high, east_hits, west_hits,
    input  ready
  );
  modport sink (
    input  valid, inner_low, inner_high, outer_low, outer_high, east_hits, west_hits,
    output ready
  );
endinterface

interface tofrt_trig_if import tofrt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               barrel_one;
  logic               barrel_two;
  logic               endcap_one;
  logic               endcap_two;
  logic               any_one;
  logic               barrel_back_to_back;
  logic               endcap_back_to_back;
  logic [LOW_W-1:0]   barrel_pos_low;
  logic [HIGH_W-1:0]  barrel_pos_high;
  logic [SCINT_W-1:0] east_scint;
  logic [SCINT_W-1:0] west_scint;

  modport source (
    output valid, barrel_one, barrel_two, endcap_one, endcap_two, any_one,
           barrel_back_to_back, endcap_back_to_back, barrel_pos_low, barrel_pos_high,
           east_scint, west_scint,
    input  ready
  );
  modport sink (
    input  valid, barrel_one, barrel_two, endcap_one, endcap_two, any_one,
           barrel_back_to_back, endcap_back_to_back, barrel_pos_low, barrel_pos_high,
           east_scint, west_scint,
    output ready
  );
endinterface

[hdl/tof_ring_trigger_logic_unit.sv]
// ----------------------------------------------------------------------------
// tof_ring_trigger_logic_unit
// Time-of-flight ring trigger: merges barrel layers, flags clusters and
// back-to-back topologies, and maps endcap channels onto scintillators.
//
//   channel  dir  handshake      content
//   hits     in   valid/ready    inner, outer, east, west hit maps
//   trig     out  valid/ready    trigger flags, barrel positions, scint maps
//   cfg      in   cfg_we         layer_mode, written when cfg_we is high
//
// One event per clock while the result is not stalled; a taken request passes the
// input register, then the result register, with the decision logic between.
// Reset (rst, synchronous) empties both stages and sets layer_mode to 2.
// A stalled result holds in place; the input stage keeps taking requests
// until both stages are full.
// ----------------------------------------------------------------------------
module tof_ring_trigger_logic_unit import tofrt_pkg::*; #(
  parameter int BARREL_COUNTERS = BARREL_COUNTERS_DEF,
  parameter int ENDCAP_CHANNELS = ENDCAP_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LAYER_W-1:0] cfg_data,
  tofrt_hits_if.sink         hits,
  tofrt_trig_if.source       trig
);

  localparam int NB = BARREL_COUNTERS;
  localparam int NE = ENDCAP_CHANNELS;

  logic [LAYER_W-1:0] layer_mode;

  // input stage
  logic                s1_valid;
  logic [LOW_W-1:0]    s1_inner_low;
  logic [HIGH_W-1:0]   s1_inner_high;
  logic [LOW_W-1:0]    s1_outer_low;
  logic [HIGH_W-1:0]   s1_outer_high;
  logic [ENDCAP_W-1:0] s1_east;
  logic [ENDCAP_W-1:0] s1_west;
  logic                s1_adv;
  logic                out_free;

  // decision logic
  logic [BARREL_MAX-1:0] inner_wide;
  logic [BARREL_MAX-1:0] outer_wide;
  logic [NB-1:0]         inner_ring;
  logic [NB-1:0]         outer_ring;
  logic [2*NB-1:0]       outer_dbl;
  logic [NB-1:0]         pos;
  logic [BARREL_MAX-1:0] pos_wide;
  logic [ENDCAP_MAX-1:0] east_wide;
  logic [ENDCAP_MAX-1:0] west_wide;
  logic [NE-1:0]         east_ring;
  logic [NE-1:0]         west_ring;
  logic [ENDCAP_MAX-1:0] east_map;
  logic [ENDCAP_MAX-1:0] west_map;
  logic [SCINT_W-1:0]    east_scint_next;
  logic [SCINT_W-1:0]    west_scint_next;
  cluster_flags_t        barrel_cl;
  cluster_flags_t        east_cl;
  cluster_flags_t        west_cl;
  logic                  barrel_b2b;
  logic                  endcap_b2b;
  logic                  endcap_one_next;
  logic                  endcap_two_next;

  assign out_free   = !trig.valid || trig.ready;
  assign s1_adv     = s1_valid && out_free;
  assign hits.ready = !s1_valid || out_free;

  // bits beyond the ring sizes are dropped
  assign inner_wide = BARREL_MAX'({s1_inner_high, s1_inner_low});
  assign outer_wide = BARREL_MAX'({s1_outer_high, s1_outer_low});
  assign inner_ring = inner_wide[NB-1:0];
  assign outer_ring = outer_wide[NB-1:0];
  assign outer_dbl  = {outer_ring, outer_ring};
  assign east_wide  = ENDCAP_MAX'(s1_east);
  assign west_wide  = ENDCAP_MAX'(s1_west);
  assign east_ring  = east_wide[NE-1:0];
  assign west_ring  = west_wide[NE-1:0];

  always_comb begin
    case (layer_mode)
      LAYER_INNER: pos = inner_ring;
      // outer counter i+1 overlaps barrel position i
      LAYER_BOTH:  pos = inner_ring | outer_ring | outer_dbl[NB:1];
      default:     pos = '0;
    endcase
  end

  assign pos_wide = BARREL_MAX'(pos);
  assign east_map = ENDCAP_MAX'(east_ring);
  assign west_map = ENDCAP_MAX'(west_ring);

  always_comb begin
    for (int k = 0; k < SCINT_W; k++) begin
      east_scint_next[k] = east_map[2*k] | east_map[2*k+1];
      west_scint_next[k] = west_map[2*k] | west_map[2*k+1];
    end
  end

  tofrt_cluster #(.N(NB)) u_barrel_cl (.ring(pos),       .flags(barrel_cl));
  tofrt_cluster #(.N(NE)) u_east_cl   (.ring(east_ring), .flags(east_cl));
  tofrt_cluster #(.N(NE)) u_west_cl   (.ring(west_ring), .flags(west_cl));

  tofrt_b2b #(.N(NB), .MIN(BB_BARREL_MIN), .SPAN(BB_BARREL_SPAN)) u_barrel_b2b (
    .anchor  (pos),
    .partner (pos),
    .flag    (barrel_b2b)
  );

  tofrt_b2b #(.N(NE), .MIN(BB_ENDCAP_MIN), .SPAN(BB_ENDCAP_SPAN)) u_endcap_b2b (
    .anchor  (west_ring),
    .partner (east_ring),
    .flag    (endcap_b2b)
  );

  // summed count reaches two from either ring alone or one from each
  assign endcap_one_next = east_cl.one | west_cl.one;
  assign endcap_two_next = east_cl.two | west_cl.two | (east_cl.one & west_cl.one);

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_mode <= LAYER_RESET;
      s1_valid   <= 1'b0;
      trig.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        layer_mode <= cfg_data;
      end
      if (hits.ready) begin
        s1_valid <= hits.valid;
      end
      if (out_free) begin
        trig.valid <= s1_valid;
      end
    end
  end

  // payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (hits.valid && hits.ready) begin
      s1_inner_low  <= hits.inner_low;
      s1_inner_high <= hits.inner_high;
      s1_outer_low  <= hits.outer_low;
      s1_outer_high <= hits.outer_high;
      s1_east       <= hits.east_hits;
      s1_west       <= hits.west_hits;
    end
    if (s1_adv) begin
      trig.barrel_one          <= barrel_cl.one;
      trig.barrel_two          <= barrel_cl.two;
      trig.endcap_one          <= endcap_one_next;
      trig.endcap_two          <= endcap_two_next;
      trig.any_one             <= barrel_cl.one | endcap_one_next;
      trig.barrel_back_to_back <= barrel_b2b;
      trig.endcap_back_to_back <= endcap_b2b;
      trig.barrel_pos_low      <= pos_wide[LOW_W-1:0];
      trig.barrel_pos_high     <= pos_wide[LOW_W+HIGH_W-1:LOW_W];
      trig.east_scint          <= east_scint_next;
      trig.west_scint          <= west_scint_next;
    end
  end

endmodule

[hdl/tofrt_cluster.sv]
// ----------------------------------------------------------------------------
// tofrt_cluster
// Cluster flags on a circular hit ring: at least one and at least two starts.
// ----------------------------------------------------------------------------
module tofrt_cluster import tofrt_pkg::*; #(
  parameter int N = BARREL_COUNTERS_DEF
) (
  input  logic [N-1:0]   ring,
  output cluster_flags_t flags
);

  logic [2*N-1:0] dbl;
  logic [N-1:0]   pred;
  logic [N-1:0]   starts;

  // predecessor of position i is i-1, position 0 looks at the last one
  assign dbl    = {ring, ring};
  assign pred   = dbl[2*N-2:N-1];
  assign starts = ring & ~pred;

  // clearing the lowest start leaves something only if there were two
  assign flags.one = |starts;
  assign flags.two = |(starts & (starts - N'(1)));

endmodule

[hdl/tofrt_b2b.sv]
// ----------------------------------------------------------------------------
// tofrt_b2b
// Back-to-back search: an anchor hit with a partner hit MIN to MIN+SPAN-1
// positions further round the ring.
// ----------------------------------------------------------------------------
module tofrt_b2b import tofrt_pkg::*; #(
  parameter int N    = BARREL_COUNTERS_DEF,
  parameter int MIN  = BB_BARREL_MIN,
  parameter int SPAN = BB_BARREL_SPAN
) (
  input  logic [N-1:0] anchor,
  input  logic [N-1:0] partner,
  output logic         flag
);

  logic [2*N-1:0] dbl;
  logic [N-1:0]   near [SPAN];
  logic [N-1:0]   reach;

  assign dbl = {partner, partner};

  // near[k][i] is partner[(i + MIN + k) mod N]
  for (genvar k = 0; k < SPAN; k++) begin : g_rot
    localparam int SH = (MIN + k) % N;
    assign near[k] = dbl[SH+N-1:SH];
  end

  always_comb begin
    reach = '0;
    for (int k = 0; k < SPAN; k++) begin
      reach = reach | near[k];
    end
  end

  assign flag = |(anchor & reach);

endmodule

[hdl/tofrt_checker.sv]
// ----------------------------------------------------------------------------
// tofrt_checker
// Port-level checks on the ring trigger, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tofrt_checker import tofrt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [LAYER_W-1:0] cfg_data,
  input logic               out_valid,
  input logic               out_ready,
  input logic               barrel_one,
  input logic               barrel_two,
  input logic               endcap_one,
  input logic               endcap_two,
  input logic               any_one,
  input logic               barrel_b2b,
  input logic [LOW_W-1:0]   barrel_pos_low,
  input logic [HIGH_W-1:0]  barrel_pos_high
);

  `include "assert_macros.svh"

  logic [LAYER_W-1:0] mode_seen;
  logic               mode_off;
  logic               pos_empty;

  // track the layer mode as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= LAYER_RESET;
    end else if (cfg_we) begin
      mode_seen <= cfg_data;
    end
  end

  assign mode_off  = (mode_seen != LAYER_INNER) && (mode_seen != LAYER_BOTH);
  assign pos_empty = (barrel_pos_low == '0) && (barrel_pos_high == '0);

  `TOFRT_ASSERT(a_any_one, out_valid |-> (any_one == (barrel_one || endcap_one)), "any_one mismatch")
  `TOFRT_ASSERT(a_two_implies_one, out_valid |-> ((!barrel_two || barrel_one) && (!endcap_two || endcap_one)), "two without one")
  `TOFRT_ASSERT(a_empty_barrel, (out_valid && (mode_off || pos_empty)) |-> (!barrel_one && !barrel_b2b && pos_empty), "barrel flags without positions")
  `TOFRT_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(barrel_pos_low) && $stable(any_one)), "stalled result changed")

endmodule

bind tof_ring_trigger_logic_unit tofrt_checker u_tofrt_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_we          (cfg_we),
  .cfg_data        (cfg_data),
  .out_valid       (trig.valid),
  .out_ready       (trig.ready),
  .barrel_one      (trig.barrel_one),
  .barrel_two      (trig.barrel_two),
  .endcap_one      (trig.endcap_one),
  .endcap_two      (trig.endcap_two),
  .any_one         (trig.any_one),
  .barrel_b2b      (trig.barrel_back_to_back),
  .barrel_pos_low  (trig.barrel_pos_low),
  .barrel_pos_high (trig.barrel_pos_high)
);

[sim/tof_ring_trigger_logic_unit_tb.sv]
// ----------------------------------------------------------------------------
// tof_ring_trigger_logic_unit_tb
// Self-checking bench for the time-of-flight ring trigger. Event hit maps are
// fed through the hits channel, and each trigger result is compared field by
// field with a prediction made when its request was taken. Layer mode is
// changed between phases, and both channels are throttled at random.
// ----------------------------------------------------------------------------
module tof_ring_trigger_logic_unit_tb import tofrt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = BARREL_COUNTERS_DEF;
  localparam int NE = ENDCAP_CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY = 2;

  // codes outside the documented range; the merged barrel map is empty
  localparam logic [LAYER_W-1:0] LAYER_OFF   = 2'd0;
  localparam logic [LAYER_W-1:0] LAYER_SPARE = 2'd3;

  localparam logic [127:0] ALL = '1;

  typedef struct packed {
    logic [LOW_W-1:0]    inner_low;
    logic [HIGH_W-1:0]   inner_high;
    logic [LOW_W-1:0]    outer_low;
    logic [HIGH_W-1:0]   outer_high;
    logic [ENDCAP_W-1:0] east_hits;
    logic [ENDCAP_W-1:0] west_hits;
  } hit_event_t;

  typedef struct packed {
    logic               barrel_one;
    logic               barrel_two;
    logic               endcap_one;
    logic               endcap_two;
    logic               any_one;
    logic               barrel_back_to_back;
    logic               endcap_back_to_back;
    logic [LOW_W-1:0]   barrel_pos_low;
    logic [HIGH_W-1:0]  barrel_pos_high;
    logic [SCINT_W-1:0] east_scint;
    logic [SCINT_W-1:0] west_scint;
  } trig_word_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LAYER_W-1:0] cfg_data;

  tofrt_hits_if hits ();
  tofrt_trig_if trig ();

  tof_ring_trigger_logic_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .hits     (hits),
    .trig     (trig)
  );

  hit_event_t         pending_events[$];
  trig_word_t         predicted_trigs[$];
  hit_event_t         next_event;
  logic [LAYER_W-1:0] layer_copy;
  logic               event_taken;
  int                 send_idle;
  int                 sink_idle;
  int                 cycles;
  int                 errors;
  int                 checked;
  int                 barrel_b2b_seen;
  int                 endcap_b2b_seen;
  int                 barrel_two_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [127:0] one_hot(int k);
    return 128'd1 << k;
  endfunction

  function automatic int count_clusters(logic [127:0] ring, int n);
    int c;
    int prev;
    c = 0;
    for (int i = 0; i < n; i++) begin
      prev = (i == 0) ? n - 1 : i - 1;
      if (ring[i] && !ring[prev]) c++;
    end
    return c;
  endfunction

  function automatic trig_word_t predict_trigger(hit_event_t h, logic [LAYER_W-1:0] mode);
    logic [NB-1:0]      inner, outer, pos;
    logic [NE-1:0]      east, west;
    logic [SCINT_W-1:0] es, ws;
    int                 bc, ec;
    trig_word_t         r;
    inner = {h.inner_high, h.inner_low};
    outer = {h.outer_high, h.outer_low};
    east  = h.east_hits;
    west  = h.west_hits;
    pos   = '0;
    for (int i = 0; i < NB; i++) begin
      case (mode)
        LAYER_INNER: pos[i] = inner[i];
        LAYER_BOTH:  pos[i] = inner[i] | outer[i] | outer[(i + 1) % NB];
        default:     pos[i] = 1'b0;
      endcase
    end
    bc = count_clusters(pos, NB);
    ec = count_clusters(east, NE) + count_clusters(west, NE);
    r = '0;
    r.barrel_one = (bc >= 1);
    r.barrel_two = (bc >= 2);
    r.endcap_one = (ec >= 1);
    r.endcap_two = (ec >= 2);
    r.any_one    = (bc >= 1) || (ec >= 1);
    for (int i = 0; i < NB; i++)
      for (int k = 0; k < BB_BARREL_SPAN; k++)
        if (pos[i] && pos[(i + BB_BARREL_MIN + k) % NB]) r.barrel_back_to_back = 1'b1;
    for (int i = 0; i < NE; i++)
      for (int k = 0; k < BB_ENDCAP_SPAN; k++)
        if (west[i] && east[(i + BB_ENDCAP_MIN + k) % NE]) r.endcap_back_to_back = 1'b1;
    es = '0;
    ws = '0;
    for (int i = 0; i < NE; i++) begin
      if (i / 2 < SCINT_W) begin
        es[i / 2] = es[i / 2] | east[i];
        ws[i / 2] = ws[i / 2] | west[i];
      end
    end
    r.barrel_pos_low  = pos[LOW_W-1:0];
    r.barrel_pos_high = pos[NB-1:LOW_W];
    r.east_scint      = es;
    r.west_scint      = ws;
    return r;
  endfunction

  function automatic hit_event_t make_event(logic [127:0] inner, logic [127:0] outer,
                                            logic [127:0] east, logic [127:0] west);
    hit_event_t h;
    h.inner_low  = inner[LOW_W-1:0];
    h.inner_high = inner[NB-1:LOW_W];
    h.outer_low  = outer[LOW_W-1:0];
    h.outer_high = outer[NB-1:LOW_W];
    h.east_hits  = east[NE-1:0];
    h.west_hits  = west[NE-1:0];
    return h;
  endfunction

  // empty, full, dense, a few short runs, or a full ring with a few holes
  function automatic logic [127:0] random_ring(int n);
    logic [127:0] r;
    int           style;
    int           p;
    int           len;
    style = $urandom_range(0, 7);
    r = {$urandom, $urandom, $urandom, $urandom};
    if (style == 0) r = '0;
    else if (style == 1) r = '1;
    else if (style >= 4) begin
      r = '0;
      repeat ($urandom_range(1, 3)) begin
        p   = $urandom_range(0, n - 1);
        len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++) r[(p + j) % n] = 1'b1;
      end
      if (style == 7) r = ~r;
    end
    return r & ((128'd1 << n) - 1);
  endfunction

  // plant pairs just around the back-to-back windows now and then
  function automatic hit_event_t random_event();
    logic [127:0] inner, outer, east, west;
    int           p;
    int           d;
    inner = random_ring(NB);
    outer = random_ring(NB);
    east  = random_ring(NE);
    west  = random_ring(NE);
    if ($urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, NB - 1);
      d = $urandom_range(BB_BARREL_MIN - 2, BB_BARREL_MIN + BB_BARREL_SPAN + 1);
      inner[p] = 1'b1;
      inner[(p + d) % NB] = 1'b1;
    end
    if ($urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, NE - 1);
      d = $urandom_range(BB_ENDCAP_MIN - 2, BB_ENDCAP_MIN + BB_ENDCAP_SPAN + 1);
      west[p] = 1'b1;
      east[(p + d) % NE] = 1'b1;
    end
    return make_event(inner, outer, east, west);
  endfunction

  // append one event to the driver's queue
  task automatic queue_event(hit_event_t h);
    pending_events.insert(pending_events.size(), h);
  endtask

  task automatic push_random(int count);
    repeat (count) queue_event(random_event());
  endtask

  task automatic push_directed();
    queue_event(make_event('0, '0, '0, '0));
    queue_event(make_event(ALL, ALL, ALL, ALL));
    queue_event(make_event(one_hot(0) | one_hot(NB - 1), '0, '0, '0));
    queue_event(make_event('0, one_hot(0), '0, '0));
    queue_event(make_event(one_hot(0) | one_hot(38), '0, '0, '0));
    queue_event(make_event(one_hot(0) | one_hot(50), '0, '0, '0));
    queue_event(make_event(one_hot(0) | one_hot(37), '0, '0, '0));
    queue_event(make_event(one_hot(0) | one_hot(51), '0, '0, '0));
    queue_event(make_event(one_hot(80) | one_hot(30), '0, '0, '0));
    queue_event(make_event(ALL, '0, ALL, ALL));
    queue_event(make_event('0, '0, one_hot(20), one_hot(0)));
    queue_event(make_event('0, '0, one_hot(28), one_hot(0)));
    queue_event(make_event('0, '0, one_hot(19), one_hot(0)));
    queue_event(make_event('0, '0, one_hot(29), one_hot(0)));
    queue_event(make_event('0, '0, one_hot(12), one_hot(40)));
    queue_event(make_event('0, '0, one_hot(0) | one_hot(NE - 1), '0));
    queue_event(make_event('0, '0, one_hot(5) | one_hot(9),
                           one_hot(46) | one_hot(47)));
    queue_event(make_event(ALL & ~one_hot(10), '0, ALL, one_hot(3)));
    queue_event(make_event('0, ALL, '0, '0));
    queue_event(make_event(one_hot(NB - 1), one_hot(NB - 1), '0, '0));
  endtask

  // hold until every request is taken and every result is back
  task automatic drain_results();
    while (pending_events.size() != 0) @(posedge clk);
    do @(negedge clk); while (hits.valid || predicted_trigs.size() != 0);
  endtask

  task automatic set_layer(logic [LAYER_W-1:0] mode);
    drain_results();
    repeat (LATENCY + 2) @(negedge clk);
    cfg_data <= mode;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // request driver: present the next event once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      hits.valid <= 1'b0;
    end else if (!hits.valid || event_taken) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        next_event       = pending_events.pop_front();
        hits.inner_low  <= next_event.inner_low;
        hits.inner_high <= next_event.inner_high;
        hits.outer_low  <= next_event.outer_low;
        hits.outer_high <= next_event.outer_high;
        hits.east_hits  <= next_event.east_hits;
        hits.west_hits  <= next_event.west_hits;
        hits.valid      <= 1'b1;
      end else begin
        hits.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) trig.ready <= 1'b0;
    else trig.ready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // monitor: predict on accepted requests, check on accepted results
  always @(posedge clk) begin
    trig_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    event_taken = !rst && hits.valid && hits.ready;
    if (!rst && trig.valid && trig.ready) begin
      if (predicted_trigs.size() == 0) begin
        $error("trigger result with no request outstanding");
        errors++;
      end else begin
        want = predicted_trigs.pop_front();
        check_field("barrel_one", want.barrel_one, trig.barrel_one);
        check_field("barrel_two", want.barrel_two, trig.barrel_two);
        check_field("endcap_one", want.endcap_one, trig.endcap_one);
        check_field("endcap_two", want.endcap_two, trig.endcap_two);
        check_field("any_one", want.any_one, trig.any_one);
        check_field("barrel_back_to_back", want.barrel_back_to_back,
                    trig.barrel_back_to_back);
        check_field("endcap_back_to_back", want.endcap_back_to_back,
                    trig.endcap_back_to_back);
        check_field("barrel_pos_low", want.barrel_pos_low, trig.barrel_pos_low);
        check_field("barrel_pos_high", want.barrel_pos_high, trig.barrel_pos_high);
        check_field("east_scint", want.east_scint, trig.east_scint);
        check_field("west_scint", want.west_scint, trig.west_scint);
        checked++;
        if (want.barrel_back_to_back) barrel_b2b_seen++;
        if (want.endcap_back_to_back) endcap_b2b_seen++;
        if (want.barrel_two) barrel_two_seen++;
      end
    end
    if (event_taken)
      predicted_trigs.insert(predicted_trigs.size(),
                             predict_trigger({hits.inner_low, hits.inner_high,
                                              hits.outer_low, hits.outer_high,
                                              hits.east_hits, hits.west_hits},
                                             layer_copy));
    if (rst) layer_copy = LAYER_RESET;
    else if (cfg_we) layer_copy = cfg_data;
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = LAYER_RESET;
    hits.valid      = 1'b0;
    hits.inner_low  = '0;
    hits.inner_high = '0;
    hits.outer_low  = '0;
    hits.outer_high = '0;
    hits.east_hits  = '0;
    hits.west_hits  = '0;
    trig.ready      = 1'b0;
    layer_copy      = LAYER_RESET;
    event_taken     = 1'b0;
    send_idle       = 23;
    sink_idle       = 23;
    cycles          = 0;
    errors          = 0;
    checked         = 0;
    barrel_b2b_seen = 0;
    endcap_b2b_seen = 0;
    barrel_two_seen = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset layer mode first, then inner only
    push_directed();
    set_layer(LAYER_INNER);
    push_directed();
    push_random(450);

    // both layers, with a full drain half way through
    set_layer(LAYER_BOTH);
    push_random(400);
    drain_results();
    push_random(400);

    set_layer(LAYER_OFF);
    push_random(120);
    set_layer(LAYER_SPARE);
    push_random(120);

    // closing stretch at full rate on both sides
    set_layer(LAYER_BOTH);
    send_idle = 0;
    sink_idle = 0;
    push_random(350);

    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    $display("checked %0d trigger results over layer modes 2, 1, 0 and 3", checked);
    $display("barrel back-to-back %0d, endcap back-to-back %0d, barrel two-cluster %0d",
             barrel_b2b_seen, endcap_b2b_seen, barrel_two_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
